// ===== rtl/assert_macros.svh =====
// assert_macros.svh
// concurrent assertion macros shared by the rtl of the row scan driver
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge out of reset
`define LMRS_ASSERT_ALWAYS(lbl, clk, rst_n, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (c)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define LMRS_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error(msg);

`else

`define LMRS_ASSERT_ALWAYS(lbl, clk, rst_n, c, msg)

`define LMRS_ASSERT_IMP(lbl, clk, rst_n, a, c, msg)

`endif

`endif

// ===== rtl/lmrs_pkg.sv =====
// lmrs_pkg.sv
// request/response payload types, register map and defaults of the row scan driver
// no dependencies
`default_nettype none

package lmrs_pkg;

    // default geometry and timing
    localparam int ROWS_DEF         = 8;
    localparam int COLUMNS_DEF      = 8;
    localparam int CHANNEL_BITS_DEF = 8;
    localparam int DOT_BITS_DEF     = 6;
    localparam int RESET_TICKS_DEF  = 16;

    // fixed field widths
    localparam int PIX_IDX_W   = 6;
    localparam int COLOR_W     = 8;
    localparam int ROW_LINES_W = 8;
    localparam int BRIGHT_W    = 6;
    localparam int DWELL_W     = 16;
    localparam int DOT_WORDS   = 24;
    localparam int DOT_WORD_W  = 5;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_DWELL  = 2'd1;

    localparam logic [BRIGHT_W-1:0] BRIGHT_RST = 6'd63;
    localparam logic [DWELL_W-1:0]  DWELL_RST  = 16'd1000;

    // request kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic [PIX_IDX_W-1:0] pixel_index;
        logic [COLOR_W-1:0]   red;
        logic [COLOR_W-1:0]   green;
        logic [COLOR_W-1:0]   blue;
    } t_req;

    typedef struct packed {
        logic                   serial_clock;
        logic                   serial_data;
        logic                   bank_select;
        logic                   latch;
        logic                   driver_reset;
        logic [ROW_LINES_W-1:0] row_lines;
    } t_res;

endpackage

`default_nettype wire

// ===== rtl/lmrs_ram.sv =====
// lmrs_ram.sv
// generic simple dual port ram, one write port, one read port with registered data
// no dependencies; read during write to the same address returns the old data
`default_nettype none

module lmrs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/led_matrix_row_scan_driver.sv =====
// led_matrix_row_scan_driver.sv
// row scan sequencer for an rgb matrix behind a two bank serial led driver
// depends on lmrs_pkg, lmrs_ram and assert_macros.svh
`default_nettype none

// Every request is either one tick of time or one pixel write, and every
// request produces exactly one response: the pin levels after that request.
// One request is taken per clock cycle and its response is presented in the
// next cycle from the pin register; a new request is taken whenever the
// response register is empty or being drained in the same cycle. The frame
// store is a ROWS*COLUMNS x 3*CHANNEL_BITS ram with a registered read port;
// it is read every cycle at the cell the sequencer will need next, and a
// pixel write to that cell in the same cycle is forwarded, so ticks never
// wait on the ram. Per-cell valid flops make unwritten pixels read as zero,
// so no clearing pass runs after reset. A tick moves the driver sequence by
// one pin phase: 2*DOT_BITS*24 + 1 ticks for a brightness reload,
// 2*CHANNEL_BITS*3*COLUMNS + 1 ticks to shift and latch a row, then the
// programmed dwell. Configuration writes are taken at any cycle with the
// write enable high and are meant for an idle block.
module led_matrix_row_scan_driver #(
    parameter int ROWS         = lmrs_pkg::ROWS_DEF,
    parameter int COLUMNS      = lmrs_pkg::COLUMNS_DEF,
    parameter int CHANNEL_BITS = lmrs_pkg::CHANNEL_BITS_DEF,
    parameter int DOT_BITS     = lmrs_pkg::DOT_BITS_DEF,
    parameter int RESET_TICKS  = lmrs_pkg::RESET_TICKS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // request channel
    input  wire logic                               i_req_valid,
    output logic                                    o_req_ready,
    input  wire lmrs_pkg::t_req                     i_req,
    // response channel
    output logic                                    o_res_valid,
    input  wire logic                               i_res_ready,
    output lmrs_pkg::t_res                          o_res,
    // configuration write port
    input  wire logic                               i_cfg_we,
    input  wire logic [lmrs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [lmrs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    `include "assert_macros.svh"

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int MW    = 3 * CHANNEL_BITS;
    localparam int SW    = (CHANNEL_BITS > DOT_BITS) ? CHANNEL_BITS : DOT_BITS;
    localparam int BCW   = $clog2(SW);
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CLW   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int DW    = lmrs_pkg::DWELL_W;

    // sequencer phases
    localparam logic [2:0] PH_RESET     = 3'd0;
    localparam logic [2:0] PH_DOT_SHIFT = 3'd1;
    localparam logic [2:0] PH_DOT_LATCH = 3'd2;
    localparam logic [2:0] PH_PIX_SHIFT = 3'd3;
    localparam logic [2:0] PH_PIX_LATCH = 3'd4;
    localparam logic [2:0] PH_DWELL     = 3'd5;

    // color channel order within a column
    localparam logic [1:0] CH_BLUE  = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_RED   = 2'd2;

    localparam logic [BCW-1:0] DOT_LAST_BIT = BCW'(DOT_BITS - 1);
    localparam logic [BCW-1:0] PIX_LAST_BIT = BCW'(CHANNEL_BITS - 1);
    localparam logic [CLW-1:0] COL_FIRST    = CLW'(COLUMNS - 1);
    localparam logic [RW-1:0]  ROW_LAST     = RW'(ROWS - 1);

    // sequencer state
    logic [2:0]                          r_phase, n_phase;
    logic [BCW-1:0]                      r_bit, n_bit;
    logic [lmrs_pkg::DOT_WORD_W-1:0]     r_word, n_word;
    logic [CLW-1:0]                      r_col, n_col;
    logic [1:0]                          r_chan, n_chan;
    logic [RW-1:0]                       r_row, n_row;
    logic [DW-1:0]                       r_tick, n_tick;
    logic                                r_half, n_half;
    logic                                r_dirty, n_dirty;
    logic [SW-1:0]                       r_shift, n_shift;
    lmrs_pkg::t_res                      r_pins, n_pins;
    logic                                r_out_valid;

    // configuration registers
    logic [lmrs_pkg::BRIGHT_W-1:0]       r_bright;
    logic [DW-1:0]                       r_dwell;

    // frame store side
    logic [CELLS-1:0]                    r_cell_valid;
    logic                                r_fwd_hit;
    logic [MW-1:0]                       r_fwd_data;
    logic                                r_rd_valid;
    logic [MW-1:0]                       ram_q;
    logic [MW-1:0]                       cur_cell;
    logic [AW-1:0]                       rd_addr;
    logic [AW-1:0]                       wr_addr;
    logic [MW-1:0]                       wr_data;
    logic                                mem_we;

    logic                                accept;
    logic                                tick_req;
    logic                                is_dot;
    logic                                start_row;
    logic [SW-1:0]                       dot_word;
    logic [SW-1:0]                       pix_word;
    logic [BCW-1:0]                      sda_idx;
    logic [DW-1:0]                       dwell_eff;
    logic [lmrs_pkg::ROW_LINES_W-1:0]    row_onehot;

    // request / response handshake
    assign o_req_ready = !r_out_valid || i_res_ready;
    assign accept      = i_req_valid && o_req_ready;
    assign tick_req    = accept && (i_req.kind == lmrs_pkg::KIND_TICK);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_pins;

    // pixel write into the frame store
    assign mem_we  = accept && (i_req.kind == lmrs_pkg::KIND_PIXEL)
                     && (int'(i_req.pixel_index) < CELLS);
    assign wr_addr = AW'(i_req.pixel_index);
    assign wr_data = {CHANNEL_BITS'(i_req.red), CHANNEL_BITS'(i_req.green),
                      CHANNEL_BITS'(i_req.blue)};

    // read the cell the sequencer will use next
    assign rd_addr = AW'(int'(n_row) * COLUMNS + int'(n_col));

    lmrs_ram #(
        .WIDTH (MW),
        .DEPTH (CELLS)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // forwarding and never-written cells
    assign cur_cell = r_fwd_hit ? r_fwd_data : (r_rd_valid ? ram_q : '0);

    // word for the current channel of the current cell
    always_comb begin
        unique case (r_chan)
            CH_BLUE:  pix_word = SW'(cur_cell[CHANNEL_BITS-1:0]);
            CH_GREEN: pix_word = SW'(cur_cell[2*CHANNEL_BITS-1:CHANNEL_BITS]);
            CH_RED:   pix_word = SW'(cur_cell[3*CHANNEL_BITS-1:2*CHANNEL_BITS]);
            default:  pix_word = '0;
        endcase
    end

    assign dot_word  = SW'(DOT_BITS'(r_bright));
    assign is_dot    = (r_phase == PH_DOT_SHIFT);
    assign sda_idx   = (is_dot ? DOT_LAST_BIT : PIX_LAST_BIT) - r_bit;
    assign dwell_eff = (r_dwell == '0) ? DW'(1) : r_dwell;

    // row enable decode, rows past the eighth have no line
    always_comb begin
        for (int i = 0; i < lmrs_pkg::ROW_LINES_W; i++) begin
            row_onehot[i] = (int'(r_row) == i);
        end
    end

    // pin sequencer
    always_comb begin
        n_phase   = r_phase;
        n_bit     = r_bit;
        n_word    = r_word;
        n_col     = r_col;
        n_chan    = r_chan;
        n_row     = r_row;
        n_tick    = r_tick;
        n_half    = r_half;
        n_dirty   = r_dirty;
        n_shift   = r_shift;
        n_pins    = r_pins;
        start_row = 1'b0;

        if (tick_req) begin
            n_pins.latch = 1'b1;
            unique case (r_phase)
                PH_RESET: begin
                    if (r_tick < DW'(RESET_TICKS)) begin
                        n_tick              = r_tick + DW'(1);
                        n_pins.driver_reset = 1'b0;
                    end else begin
                        n_tick              = '0;
                        n_pins.driver_reset = 1'b1;
                        start_row           = 1'b1;
                    end
                end
                PH_DOT_SHIFT, PH_PIX_SHIFT: begin
                    n_pins.bank_select = !is_dot;
                    if (!r_half) begin
                        // first half: clock low, data placed
                        if (r_bit == '0) begin
                            n_shift = is_dot ? dot_word : pix_word;
                        end
                        n_pins.serial_clock = 1'b0;
                        n_pins.serial_data  = n_shift[sda_idx];
                        n_half              = 1'b1;
                    end else begin
                        // second half: clock high, step bit and word
                        n_pins.serial_clock = 1'b1;
                        n_half              = 1'b0;
                        if (r_bit == (is_dot ? DOT_LAST_BIT : PIX_LAST_BIT)) begin
                            n_bit = '0;
                            if (is_dot) begin
                                if (r_word == lmrs_pkg::DOT_WORD_W'(lmrs_pkg::DOT_WORDS - 1)) begin
                                    n_word  = '0;
                                    n_phase = PH_DOT_LATCH;
                                end else begin
                                    n_word = r_word + 1'b1;
                                end
                            end else if (r_chan == CH_RED) begin
                                n_chan = CH_BLUE;
                                if (r_col == '0) begin
                                    n_col   = COL_FIRST;
                                    n_phase = PH_PIX_LATCH;
                                end else begin
                                    n_col = r_col - 1'b1;
                                end
                            end else begin
                                n_chan = r_chan + 1'b1;
                            end
                        end else begin
                            n_bit = r_bit + 1'b1;
                        end
                    end
                end
                PH_DOT_LATCH: begin
                    n_pins.serial_clock = 1'b0;
                    n_pins.serial_data  = 1'b0;
                    n_pins.latch        = 1'b0;
                    n_phase             = PH_PIX_SHIFT;
                    n_word              = '0;
                    n_bit               = '0;
                    n_half              = 1'b0;
                    n_col               = COL_FIRST;
                    n_chan              = CH_BLUE;
                end
                PH_PIX_LATCH: begin
                    // rows switch only here, together with the latch of the new row
                    n_pins.serial_clock = 1'b0;
                    n_pins.serial_data  = 1'b0;
                    n_pins.latch        = 1'b0;
                    n_pins.row_lines    = row_onehot;
                    n_tick              = '0;
                    n_phase             = PH_DWELL;
                end
                PH_DWELL: begin
                    n_tick = r_tick + DW'(1);
                    if (n_tick >= dwell_eff) begin
                        n_tick    = '0;
                        n_row     = (r_row == ROW_LAST) ? '0 : r_row + 1'b1;
                        start_row = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        // next row sequence, with a bank 0 reload first when pending
        if (start_row) begin
            n_word = '0;
            n_bit  = '0;
            n_half = 1'b0;
            n_col  = COL_FIRST;
            n_chan = CH_BLUE;
            if (r_dirty) begin
                n_dirty = 1'b0;
                n_phase = PH_DOT_SHIFT;
            end else begin
                n_phase = PH_PIX_SHIFT;
            end
        end

        // brightness write schedules a reload
        if (i_cfg_we && (i_cfg_idx == lmrs_pkg::REG_BRIGHTNESS)) begin
            n_dirty = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase             <= PH_RESET;
            r_bit               <= '0;
            r_word              <= '0;
            r_col               <= COL_FIRST;
            r_chan              <= CH_BLUE;
            r_row               <= '0;
            r_tick              <= '0;
            r_half              <= 1'b0;
            r_dirty             <= 1'b1;
            r_shift             <= '0;
            r_pins.serial_clock <= 1'b0;
            r_pins.serial_data  <= 1'b0;
            r_pins.bank_select  <= 1'b0;
            r_pins.latch        <= 1'b1;
            r_pins.driver_reset <= 1'b0;
            r_pins.row_lines    <= '0;
            r_out_valid         <= 1'b0;
            r_cell_valid        <= '0;
            r_fwd_hit           <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_bit       <= n_bit;
            r_word      <= n_word;
            r_col       <= n_col;
            r_chan      <= n_chan;
            r_row       <= n_row;
            r_tick      <= n_tick;
            r_half      <= n_half;
            r_dirty     <= n_dirty;
            r_shift     <= n_shift;
            r_pins      <= n_pins;
            r_fwd_hit   <= mem_we && (wr_addr == rd_addr);
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            if (mem_we) begin
                r_cell_valid[wr_addr] <= 1'b1;
            end
        end
    end

    // forwarded data and valid flag of the cell being read
    always_ff @(posedge i_clk) begin
        r_fwd_data <= wr_data;
        r_rd_valid <= r_cell_valid[rd_addr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright <= lmrs_pkg::BRIGHT_RST;
            r_dwell  <= lmrs_pkg::DWELL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lmrs_pkg::REG_BRIGHTNESS: r_bright <= i_cfg_data[lmrs_pkg::BRIGHT_W-1:0];
                lmrs_pkg::REG_ROW_DWELL:  r_dwell  <= i_cfg_data[DW-1:0];
                default: begin
                end
            endcase
        end
    end

    // checks
    `LMRS_ASSERT_ALWAYS(a_rows_onehot, i_clk, i_rst_n, $onehot0(r_pins.row_lines), "two rows lit")
    `LMRS_ASSERT_IMP(a_latch_phase, i_clk, i_rst_n, !r_pins.latch, (r_phase == PH_DWELL || r_phase == PH_PIX_SHIFT), "latch low outside a latch step")
    `LMRS_ASSERT_IMP(a_reset_phase, i_clk, i_rst_n, !r_pins.driver_reset, (r_phase == PH_RESET), "driver reset low after reset phase")
    `LMRS_ASSERT_IMP(a_half_clock, i_clk, i_rst_n, ((r_phase == PH_DOT_SHIFT || r_phase == PH_PIX_SHIFT) && r_half), !r_pins.serial_clock, "clock high in first half of a bit")

endmodule

`default_nettype wire

// ===== verif/tb_led_matrix_row_scan_driver.sv =====
// tb_led_matrix_row_scan_driver.sv
// self-checking testbench for the row scan driver: directed table, then random requests
// depends on lmrs_pkg and led_matrix_row_scan_driver
`default_nettype none

module tb_led_matrix_row_scan_driver;

    import lmrs_pkg::*;

    localparam int PIX_WORDS     = 3 * COLUMNS_DEF;
    localparam int CELLS         = ROWS_DEF * COLUMNS_DEF;
    localparam int CHUNK_ITEMS   = 62;
    localparam int CHUNKS        = 2;
    localparam int PIXEL_PCT     = 15;

    // register indexes that map to nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

    // pin levels that can be read off directly
    localparam t_res PINS_IN_RESET = '{serial_clock: 1'b0, serial_data: 1'b0,
                                       bank_select: 1'b0, latch: 1'b1,
                                       driver_reset: 1'b0, row_lines: '0};
    localparam t_res PINS_RELEASED = '{serial_clock: 1'b0, serial_data: 1'b0,
                                       bank_select: 1'b0, latch: 1'b1,
                                       driver_reset: 1'b1, row_lines: '0};
    localparam t_res PINS_DOT_MSB  = '{serial_clock: 1'b0, serial_data: 1'b1,
                                       bank_select: 1'b0, latch: 1'b1,
                                       driver_reset: 1'b1, row_lines: '0};

    typedef enum logic [2:0] {
        SCAN_RESET,
        SCAN_DOT_SHIFT,
        SCAN_DOT_LATCH,
        SCAN_PIX_SHIFT,
        SCAN_PIX_LATCH,
        SCAN_DWELL
    } t_scan_phase;

    typedef struct {
        t_req item;
        bit   has_pins;
        t_res pins;
    } t_directed_row;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    t_req req_bus;
    logic res_valid;
    logic res_ready;
    t_res res_bus;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int send_idle_pct;
    int recv_idle_pct;
    int mismatch_count = 0;

    // expected pin levels, oldest first
    t_res pins_due[$];
    t_res pins_head;
    t_directed_row directed_rows[$];

    // predicted driver state
    logic [COLOR_W-1:0] pixel_store [CELLS][3];   // 0 blue, 1 green, 2 red
    t_scan_phase        scan_phase;
    int                 scan_bit;
    int                 scan_word;
    int                 scan_row;
    int                 scan_ticks;
    bit                 scan_half;
    bit                 dot_reload;
    logic [7:0]         scan_shift;
    logic [BRIGHT_W-1:0] dot_value;
    logic [DWELL_W-1:0]  dwell_value;
    t_res               pin_state;

    led_matrix_row_scan_driver DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req_bus),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // start of a row: reload dot correction first when a reload is pending
    function automatic void start_row();
        scan_word = 0;
        scan_bit  = 0;
        scan_half = 1'b0;
        if (dot_reload) begin
            dot_reload = 1'b0;
            scan_phase = SCAN_DOT_SHIFT;
        end else begin
            scan_phase = SCAN_PIX_SHIFT;
        end
    endfunction

    // one half-bit of the serial shift; returns 1 after the last bit of the last word
    function automatic bit shift_step(input bit dot);
        int nbits;
        int nwords;
        int cell_idx;
        nbits  = dot ? DOT_BITS_DEF : CHANNEL_BITS_DEF;
        nwords = dot ? DOT_WORDS : PIX_WORDS;
        pin_state.bank_select = ~dot;
        if (!scan_half) begin
            if (scan_bit == 0) begin
                cell_idx = (scan_row % ROWS_DEF) * COLUMNS_DEF + COLUMNS_DEF - 1
                           - scan_word / 3;
                scan_shift = dot ? 8'(dot_value) : pixel_store[cell_idx][scan_word % 3];
            end
            pin_state.serial_clock = 1'b0;
            pin_state.serial_data  = scan_shift[nbits - 1 - scan_bit];
            scan_half = 1'b1;
            return 1'b0;
        end
        pin_state.serial_clock = 1'b1;
        scan_half = 1'b0;
        scan_bit++;
        if (scan_bit >= nbits) begin
            scan_bit = 0;
            scan_word++;
            if (scan_word >= nwords) begin
                scan_word = 0;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // pin levels after one accepted request
    function automatic t_res next_pins(input t_req item);
        int dwell;
        if (item.kind == KIND_PIXEL) begin
            pixel_store[item.pixel_index][0] = item.blue;
            pixel_store[item.pixel_index][1] = item.green;
            pixel_store[item.pixel_index][2] = item.red;
            return pin_state;
        end
        dwell = (dwell_value == 0) ? 1 : int'(dwell_value);
        pin_state.latch = 1'b1;
        case (scan_phase)
            SCAN_RESET: begin
                if (scan_ticks < RESET_TICKS_DEF) begin
                    scan_ticks++;
                    pin_state.driver_reset = 1'b0;
                end else begin
                    scan_ticks = 0;
                    pin_state.driver_reset = 1'b1;
                    start_row();
                end
            end
            SCAN_DOT_SHIFT: begin
                if (shift_step(1'b1)) scan_phase = SCAN_DOT_LATCH;
            end
            SCAN_DOT_LATCH: begin
                pin_state.serial_clock = 1'b0;
                pin_state.serial_data  = 1'b0;
                pin_state.latch        = 1'b0;
                scan_phase = SCAN_PIX_SHIFT;
                scan_word  = 0;
                scan_bit   = 0;
                scan_half  = 1'b0;
            end
            SCAN_PIX_SHIFT: begin
                if (shift_step(1'b0)) scan_phase = SCAN_PIX_LATCH;
            end
            SCAN_PIX_LATCH: begin
                // the new row lights only on the latch tick
                pin_state.serial_clock = 1'b0;
                pin_state.serial_data  = 1'b0;
                pin_state.latch        = 1'b0;
                pin_state.row_lines    = ROW_LINES_W'(1 << (scan_row % ROWS_DEF));
                scan_ticks = 0;
                scan_phase = SCAN_DWELL;
            end
            default: begin
                scan_ticks++;
                if (scan_ticks >= dwell) begin
                    scan_ticks = 0;
                    scan_row   = (scan_row + 1) % ROWS_DEF;
                    start_row();
                end
            end
        endcase
        return pin_state;
    endfunction

    task automatic add_row(input logic kind, input int idx, input int red, input int green,
                           input int blue, input bit has_pins, input t_res pins);
        t_directed_row row;
        row.item.kind        = kind;
        row.item.pixel_index = PIX_IDX_W'(idx);
        row.item.red         = COLOR_W'(red);
        row.item.green       = COLOR_W'(green);
        row.item.blue        = COLOR_W'(blue);
        row.has_pins         = has_pins;
        row.pins             = pins;
        directed_rows.push_back(row);
    endtask

    // offer one request, hold it until taken, then record what it should produce
    task automatic send_request(input t_req item, input bit has_pins, input t_res pins);
        t_res predicted;
        while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk);
        req_valid = 1'b1;
        req_bus   = item;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        predicted = next_pins(item);
        pins_due.push_back(has_pins ? pins : predicted);
        @(negedge clk);
        req_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pins_due.size() != 0) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_BRIGHTNESS) begin
            dot_value  = data[BRIGHT_W-1:0];
            dot_reload = 1'b1;
        end else if (idx == REG_ROW_DWELL) begin
            dwell_value = data;
        end
    endtask

    task automatic check_pin(input string pin_name, input int unsigned want,
                             input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", pin_name, want, got);
            mismatch_count++;
        end
    endtask

    // receiver stalls
    always @(negedge clk) begin
        res_ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // compare every accepted response with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready) begin
            if (pins_due.size() == 0) begin
                $error("response with no request pending: %h", res_bus);
                mismatch_count++;
            end else begin
                pins_head = pins_due.pop_front();
                check_pin("serial_clock", pins_head.serial_clock, res_bus.serial_clock);
                check_pin("serial_data", pins_head.serial_data, res_bus.serial_data);
                check_pin("bank_select", pins_head.bank_select, res_bus.bank_select);
                check_pin("latch", pins_head.latch, res_bus.latch);
                check_pin("driver_reset", pins_head.driver_reset, res_bus.driver_reset);
                check_pin("row_lines", pins_head.row_lines, res_bus.row_lines);
            end
        end
    end

    initial begin
        t_req        item;
        int          near_row;
        int          dwell_pick;
        int          pcts [3][2];

        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req_bus       = '0;
        res_ready     = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_data      = '0;
        send_idle_pct = 23;
        recv_idle_pct = 77;

        // predictor at its reset state
        for (int c = 0; c < CELLS; c++) begin
            for (int ch = 0; ch < 3; ch++) pixel_store[c][ch] = '0;
        end
        scan_phase  = SCAN_RESET;
        scan_bit    = 0;
        scan_word   = 0;
        scan_row    = 0;
        scan_ticks  = 0;
        scan_half   = 1'b0;
        dot_reload  = 1'b1;
        scan_shift  = '0;
        dot_value   = BRIGHT_RST;
        dwell_value = DWELL_RST;
        pin_state   = PINS_IN_RESET;

        // directed table: pixel writes repeat the pins, reset holds for its ticks
        add_row(KIND_TICK,   0,    0,    0,    0,    1, PINS_IN_RESET);
        add_row(KIND_PIXEL,  0,    8'hff, 8'hff, 8'hff, 1, PINS_IN_RESET);
        add_row(KIND_PIXEL,  63,   8'h00, 8'h00, 8'h00, 1, PINS_IN_RESET);
        add_row(KIND_PIXEL,  7,    8'haa, 8'h55, 8'hff, 1, PINS_IN_RESET);
        add_row(KIND_PIXEL,  56,   8'h55, 8'haa, 8'h00, 1, PINS_IN_RESET);
        add_row(KIND_PIXEL,  42,   8'h80, 8'h01, 8'h7f, 1, PINS_IN_RESET);
        add_row(KIND_PIXEL,  21,   8'h01, 8'h80, 8'hfe, 1, PINS_IN_RESET);
        for (int t = 1; t < RESET_TICKS_DEF; t++)
            add_row(KIND_TICK, 0, 0, 0, 0, 1, PINS_IN_RESET);
        add_row(KIND_TICK,   0,    0,    0,    0,    1, PINS_RELEASED);
        add_row(KIND_TICK,   0,    0,    0,    0,    1, PINS_DOT_MSB);
        add_row(KIND_TICK,   0,    0,    0,    0,    0, PINS_DOT_MSB);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].item, directed_rows[i].has_pins,
                         directed_rows[i].pins);

        // random part: a full frame scan takes more ticks than the random part sends
        pcts = '{'{23, 77}, '{77, 23}, '{0, 0}};
        for (int p = 0; p < 3; p++) begin
            send_idle_pct = pcts[p][0];
            recv_idle_pct = pcts[p][1];
            for (int c = 0; c < CHUNKS; c++) begin
                // settings change only with nothing in flight
                wait_drained();
                if (p == 0 && c == 0) begin
                    write_register(REG_BRIGHTNESS, 16'hffc0);
                    write_register(REG_ROW_DWELL, 16'h0000);
                    write_register(REG_UNMAPPED_LO, 16'hffff);
                    write_register(REG_UNMAPPED_HI, 16'h5a5a);
                end else if (p == 0 && c == 1) begin
                    write_register(REG_BRIGHTNESS, 16'h003f);
                    write_register(REG_ROW_DWELL, 16'hffff);
                end else begin
                    if ($urandom_range(0, 1) == 1)
                        write_register(REG_BRIGHTNESS, CFG_DATA_W'($urandom));
                    dwell_pick = $urandom_range(0, 5);
                    if (dwell_pick == 0)
                        write_register(REG_ROW_DWELL, 16'h0000);
                    else if (dwell_pick == 1)
                        write_register(REG_ROW_DWELL, DWELL_W'($urandom_range(100, 400)));
                    else
                        write_register(REG_ROW_DWELL, DWELL_W'($urandom_range(1, 6)));
                end
                for (int n = 0; n < CHUNK_ITEMS; n++) begin
                    // sender holds off until the pipe is empty at mid-chunk and now and then at random
                    if (n == CHUNK_ITEMS / 2 || $urandom_range(0, 199) == 0)
                        wait_drained();
                    item.kind  = ($urandom_range(0, 99) < PIXEL_PCT) ? KIND_PIXEL : KIND_TICK;
                    item.red   = COLOR_W'($urandom);
                    item.green = COLOR_W'($urandom);
                    item.blue  = COLOR_W'($urandom);
                    // half the writes land in the row on screen or the one coming up
                    if ($urandom_range(0, 1) == 1) begin
                        near_row = (scan_row + $urandom_range(0, 1)) % ROWS_DEF;
                        item.pixel_index = {3'(near_row), 3'($urandom)};
                    end else begin
                        item.pixel_index = PIX_IDX_W'($urandom);
                    end
                    send_request(item, 1'b0, PINS_IN_RESET);
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
